// ----- sv/mexp_pkg.sv -----
package mexp_pkg;

    // Width of the base field and of the result field.
    localparam int BASE_WIDTH   = 63;
    localparam int RESULT_WIDTH = 32;

    // Reset value of the modulus register.
    localparam logic [63:0] MODULUS_RESET = 64'd1000000007;

    // Opcodes.
    localparam logic OP_POWER   = 1'b0;
    localparam logic OP_INVERSE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_REDUCE,
        ST_NEXT,
        ST_MUL,
        ST_SQR,
        ST_DONE
    } t_state;

endpackage

// ----- sv/modular_exponentiation.sv -----
// Modular exponentiation, right-to-left square and multiply.
// A request is taken at a rising edge with start high and busy low; it carries
// i_opcode (power, or Fermat inverse with exponent modulus minus two),
// i_base_value and i_exponent. busy stays high until the result has been shown.
// The result on o_power_result is marked by o_done, high for exactly one cycle;
// the receiver cannot stall it, so it must take it in that cycle.
// The user must write the modulus through i_cfg_we / i_cfg_wdata only while
// the block is idle; the block itself does not enforce this.
// One shift, add and compare-subtract unit does all the arithmetic: it reduces
// the base one bit per cycle, then makes one decision per exponent bit, a
// multiply for each set bit and a square for each bit below the top one.
// When the modulus is zero the block goes straight to the strobe. A new request
// can be taken from the cycle after the strobe.
// A zero exponent gives 1 for any nonzero modulus and 0 for a zero modulus.
// Reset returns the sequencer to idle and the modulus to 1000000007.
module modular_exponentiation #(
    parameter int MOD_WIDTH = 32,
    parameter int EXP_WIDTH = 63
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                start,
    output logic                                busy,
    input  logic                                i_opcode,
    input  logic [mexp_pkg::BASE_WIDTH-1:0]     i_base_value,
    input  logic [EXP_WIDTH-1:0]                i_exponent,
    input  logic                                i_cfg_we,
    input  logic [MOD_WIDTH-1:0]                i_cfg_wdata,
    output logic                                o_done,
    output logic [mexp_pkg::RESULT_WIDTH-1:0]   o_power_result
);

    localparam int BW      = mexp_pkg::BASE_WIDTH;
    localparam int CNT_MAX = (BW > MOD_WIDTH) ? BW : MOD_WIDTH;
    localparam int CNT_W   = $clog2(CNT_MAX);

    mexp_pkg::t_state r_state, n_state;

    logic [MOD_WIDTH-1:0] r_modulus;
    logic [MOD_WIDTH-1:0] r_acc, n_acc;
    logic [MOD_WIDTH-1:0] r_b, n_b;
    logic [MOD_WIDTH-1:0] r_prod, n_prod;
    logic [MOD_WIDTH-1:0] r_mcand, n_mcand;
    logic [MOD_WIDTH-1:0] r_mplier, n_mplier;
    logic [BW-1:0]        r_base_sh, n_base_sh;
    logic [EXP_WIDTH-1:0] r_exp, n_exp;
    logic [CNT_W-1:0]     r_cnt, n_cnt;

    logic [63:0]          mod_ext;
    logic [63:0]          inv_exp_ext;
    logic [63:0]          acc_ext;
    logic [MOD_WIDTH+1:0] u_addend;
    logic [MOD_WIDTH+1:0] u_sum;
    logic [MOD_WIDTH+1:0] u_once_m;
    logic [MOD_WIDTH+1:0] u_twice_m;
    logic [MOD_WIDTH+1:0] u_red;
    logic [MOD_WIDTH-1:0] u_out;

    // Exponent for the inverse: modulus minus two, or zero below two.
    assign mod_ext     = 64'(r_modulus);
    assign inv_exp_ext = (mod_ext >= 64'd2) ? (mod_ext - 64'd2) : 64'd0;
    assign acc_ext     = 64'(r_acc);

    // Shared unit: r = 2r + addend, brought back below the modulus. With r below
    // the modulus and the addend below it too, the sum stays under three moduli.
    always_comb begin
        if (r_state == mexp_pkg::ST_REDUCE) begin
            u_addend = (MOD_WIDTH+2)'(r_base_sh[BW-1]);
        end else if (r_mplier[MOD_WIDTH-1]) begin
            u_addend = {2'b00, r_mcand};
        end else begin
            u_addend = '0;
        end
        u_sum     = {1'b0, r_prod, 1'b0} + u_addend;
        u_once_m  = {2'b00, r_modulus};
        u_twice_m = {1'b0, r_modulus, 1'b0};
        if (u_sum >= u_twice_m) begin
            u_red = u_sum - u_twice_m;
        end else if (u_sum >= u_once_m) begin
            u_red = u_sum - u_once_m;
        end else begin
            u_red = u_sum;
        end
        u_out = u_red[MOD_WIDTH-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= mexp_pkg::ST_IDLE;
            r_modulus <= mexp_pkg::MODULUS_RESET[MOD_WIDTH-1:0];
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_modulus <= i_cfg_wdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_acc     <= n_acc;
        r_b       <= n_b;
        r_prod    <= n_prod;
        r_mcand   <= n_mcand;
        r_mplier  <= n_mplier;
        r_base_sh <= n_base_sh;
        r_exp     <= n_exp;
        r_cnt     <= n_cnt;
    end

    always_comb begin
        n_state   = r_state;
        n_acc     = r_acc;
        n_b       = r_b;
        n_prod    = r_prod;
        n_mcand   = r_mcand;
        n_mplier  = r_mplier;
        n_base_sh = r_base_sh;
        n_exp     = r_exp;
        n_cnt     = r_cnt;

        unique case (r_state)
            mexp_pkg::ST_IDLE: begin
                if (start) begin
                    n_acc     = MOD_WIDTH'(1);
                    n_prod    = '0;
                    n_base_sh = i_base_value;
                    n_cnt     = CNT_W'(BW - 1);
                    if (i_opcode == mexp_pkg::OP_INVERSE) begin
                        n_exp = inv_exp_ext[EXP_WIDTH-1:0];
                    end else begin
                        n_exp = i_exponent;
                    end
                    if (r_modulus == '0) begin
                        n_acc   = '0;
                        n_state = mexp_pkg::ST_DONE;
                    end else begin
                        n_state = mexp_pkg::ST_REDUCE;
                    end
                end
            end
            mexp_pkg::ST_REDUCE: begin
                n_prod    = u_out;
                n_base_sh = r_base_sh << 1;
                if (r_cnt == '0) begin
                    n_b     = u_out;
                    n_state = mexp_pkg::ST_NEXT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            mexp_pkg::ST_NEXT: begin
                n_prod  = '0;
                n_mcand = r_b;
                n_cnt   = CNT_W'(MOD_WIDTH - 1);
                if (r_exp == '0) begin
                    n_state = mexp_pkg::ST_DONE;
                end else if (r_exp[0]) begin
                    n_mplier = r_acc;
                    n_state  = mexp_pkg::ST_MUL;
                end else begin
                    n_mplier = r_b;
                    n_state  = mexp_pkg::ST_SQR;
                end
            end
            mexp_pkg::ST_MUL: begin
                n_prod   = u_out;
                n_mplier = r_mplier << 1;
                if (r_cnt == '0) begin
                    n_acc = u_out;
                    // The square after the top exponent bit would be discarded.
                    if (r_exp[EXP_WIDTH-1:1] == '0) begin
                        n_state = mexp_pkg::ST_DONE;
                    end else begin
                        n_prod   = '0;
                        n_mplier = r_b;
                        n_cnt    = CNT_W'(MOD_WIDTH - 1);
                        n_state  = mexp_pkg::ST_SQR;
                    end
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            mexp_pkg::ST_SQR: begin
                n_prod   = u_out;
                n_mplier = r_mplier << 1;
                if (r_cnt == '0) begin
                    n_b     = u_out;
                    n_exp   = r_exp >> 1;
                    n_state = mexp_pkg::ST_NEXT;
                end else begin
                    n_cnt = r_cnt - 1'b1;
                end
            end
            mexp_pkg::ST_DONE: begin
                n_state = mexp_pkg::ST_IDLE;
            end
            default: begin
                n_state = mexp_pkg::ST_IDLE;
            end
        endcase
    end

    assign busy           = (r_state != mexp_pkg::ST_IDLE);
    assign o_done         = (r_state == mexp_pkg::ST_DONE);
    assign o_power_result = acc_ext[mexp_pkg::RESULT_WIDTH-1:0];

`ifndef NO_ASSERTIONS
    a_start_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("request accepted but block not busy");

    a_done_pulse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |=> (!o_done && !busy))
        else $error("result strobe longer than one cycle");

    a_prod_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::ST_REDUCE || r_state == mexp_pkg::ST_MUL ||
         r_state == mexp_pkg::ST_SQR) |-> (r_prod < r_modulus))
        else $error("partial product not below the modulus");

    a_base_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == mexp_pkg::ST_NEXT) |-> (r_b < r_modulus))
        else $error("base not below the modulus");
`endif

endmodule

// ----- tb/sv/tb_top.sv -----
`timescale 1ns / 100ps

module tb_top;

    localparam int MOD_BITS       = 32;
    localparam int EXP_BITS       = 63;
    localparam int BASE_BITS      = mexp_pkg::BASE_WIDTH;
    localparam int RESULT_BITS    = mexp_pkg::RESULT_WIDTH;
    localparam int STALL_LIMIT    = 20000;
    localparam int PHASE_REQUESTS = 136;

    logic                   i_clk;
    logic                   i_rst_n        = 1'b0;
    logic                   start          = 1'b0;
    logic                   busy;
    logic                   i_opcode       = mexp_pkg::OP_POWER;
    logic [BASE_BITS-1:0]   i_base_value   = '0;
    logic [EXP_BITS-1:0]    i_exponent     = '0;
    logic                   i_cfg_we       = 1'b0;
    logic [MOD_BITS-1:0]    i_cfg_wdata    = '0;
    logic                   o_done;
    logic [RESULT_BITS-1:0] o_power_result;

    // Shadow of the modulus register, as last written by the test.
    logic [MOD_BITS-1:0]    modulus_q = mexp_pkg::MODULUS_RESET[MOD_BITS-1:0];
    logic [RESULT_BITS-1:0] pending_powers[$];
    logic [RESULT_BITS-1:0] wanted_power;

    int unsigned requests_sent    = 0;
    int unsigned inverse_requests = 0;
    int unsigned full_exponents   = 0;
    int unsigned powers_checked   = 0;
    int unsigned moduli_written   = 0;
    int unsigned error_count      = 0;
    int unsigned stall_cycles     = 0;
    bit          sender_gaps_on   = 1'b1;

    modular_exponentiation #(
        .MOD_WIDTH (MOD_BITS),
        .EXP_WIDTH (EXP_BITS)
    ) uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .start          (start),
        .busy           (busy),
        .i_opcode       (i_opcode),
        .i_base_value   (i_base_value),
        .i_exponent     (i_exponent),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .o_done         (o_done),
        .o_power_result (o_power_result)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // Square and multiply over the shadow modulus; products stay below 2^64.
    function automatic logic [RESULT_BITS-1:0] expected_power(
        input logic                 op,
        input logic [BASE_BITS-1:0] base,
        input logic [EXP_BITS-1:0]  expo
    );
        logic [63:0]         m;
        logic [63:0]         b;
        logic [63:0]         acc;
        logic [EXP_BITS-1:0] e;
        m   = {32'd0, modulus_q};
        e   = expo;
        acc = 64'd1;
        if (op == mexp_pkg::OP_INVERSE) begin
            e = (m >= 64'd2) ? EXP_BITS'(m - 64'd2) : '0;
        end
        if (m == 64'd0) begin
            return '0;
        end
        b = {1'b0, base} % m;
        while (e != '0) begin
            if (e[0]) begin
                acc = ((acc % m) * b) % m;
            end
            b = (b * b) % m;
            e = e >> 1;
        end
        return acc[RESULT_BITS-1:0];
    endfunction

    function automatic logic [EXP_BITS-1:0] pick_exponent();
        int                  kind;
        int                  len;
        logic [EXP_BITS-1:0] r;
        kind = $urandom_range(0, 99);
        r    = EXP_BITS'({$urandom, $urandom});
        if (kind < 5) begin
            return '0;
        end
        // Mostly short exponents: the latency grows with every exponent bit.
        if (kind < 60) begin
            len = $urandom_range(1, 6);
        end else if (kind < 95) begin
            len = $urandom_range(7, 14);
        end else if (kind < 98) begin
            len = $urandom_range(15, 40);
        end else begin
            len = EXP_BITS;
        end
        return (r >> (EXP_BITS - len)) | (EXP_BITS'(1) << (len - 1));
    endfunction

    function automatic logic [BASE_BITS-1:0] pick_base();
        int                   kind;
        logic [BASE_BITS-1:0] r;
        kind = $urandom_range(0, 99);
        r    = BASE_BITS'({$urandom, $urandom});
        if (kind < 75) begin
            return r;
        end
        if (kind < 85) begin
            return BASE_BITS'($urandom_range(0, 1000));
        end
        // Multiples of the modulus and their neighbours.
        if (kind < 95) begin
            return BASE_BITS'(modulus_q) * BASE_BITS'($urandom_range(0, 7))
                   + BASE_BITS'($urandom_range(0, 2)) - BASE_BITS'(1);
        end
        if (kind < 97) begin
            return '0;
        end
        return '1;
    endfunction

    // Holds the request on the ports until the block takes it. start is left
    // high afterwards so that a back-to-back request does not need start to fall and rise again.
    task automatic send_request(
        input logic                 op,
        input logic [BASE_BITS-1:0] base,
        input logic [EXP_BITS-1:0]  expo
    );
        int gap;
        gap = sender_gaps_on ? $urandom_range(0, 3) : 0;
        if (gap > 0) begin
            start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        start        <= 1'b1;
        i_opcode     <= op;
        i_base_value <= base;
        i_exponent   <= expo;
        do @(posedge i_clk); while (busy);
        pending_powers = {pending_powers, expected_power(op, base, expo)};
        requests_sent++;
        if (op == mexp_pkg::OP_INVERSE) inverse_requests++;
        if (expo[EXP_BITS-1] && op == mexp_pkg::OP_POWER) full_exponents++;
    endtask

    task automatic drain_requests();
        start <= 1'b0;
        @(posedge i_clk);
        while (pending_powers.size() != 0 || busy) @(posedge i_clk);
    endtask

    // Drains all requests so that the block is idle when the modulus is written.
    task automatic set_modulus(input logic [MOD_BITS-1:0] value);
        drain_requests();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        modulus_q    = value;
        moduli_written++;
        @(posedge i_clk);
    endtask

    task automatic test_reset_modulus();
        send_request(mexp_pkg::OP_POWER, '0, '0);
        send_request(mexp_pkg::OP_POWER, '1, '0);
        send_request(mexp_pkg::OP_POWER, '0, EXP_BITS'(5));
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(2), EXP_BITS'(10));
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(64'd5000000038), EXP_BITS'(1));
        send_request(mexp_pkg::OP_POWER, '1, '1);
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(3), '0);
        // No inverse exists for a multiple of the modulus.
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(64'd3000000021), '1);
        send_request(mexp_pkg::OP_INVERSE, '1, EXP_BITS'({(EXP_BITS/2+1){2'b10}}));
    endtask

    task automatic test_degenerate_moduli();
        set_modulus(MOD_BITS'(1));
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(7), '0);
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(7), EXP_BITS'(9));
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(5), EXP_BITS'(9));
        // A zero modulus gives zero for everything, a zero exponent included.
        set_modulus('0);
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(5), '0);
        send_request(mexp_pkg::OP_POWER, '1, '1);
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(5), '0);
        set_modulus(MOD_BITS'(2));
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(3), '1);
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(3), EXP_BITS'(1));
    endtask

    task automatic test_full_width_moduli();
        set_modulus('1);
        send_request(mexp_pkg::OP_POWER, '1, '1);
        send_request(mexp_pkg::OP_POWER, BASE_BITS'(32'hFFFF_FFFE), EXP_BITS'(2));
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'({$urandom, $urandom}), '0);
        set_modulus(MOD_BITS'(32'd4294967291));
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'({$urandom, $urandom}),
                     EXP_BITS'({$urandom, $urandom}));
        send_request(mexp_pkg::OP_INVERSE, BASE_BITS'(32'd4294967290), '0);
    endtask

    task automatic test_random_sweep();
        logic [MOD_BITS-1:0] moduli[12];
        logic                op;
        moduli = '{MOD_BITS'(32'd1000000007), MOD_BITS'(32'd4294967291), '1,
                   MOD_BITS'(65521), MOD_BITS'(251), MOD_BITS'(3), MOD_BITS'(2),
                   MOD_BITS'(1), '0, MOD_BITS'($urandom),
                   MOD_BITS'($urandom_range(4, 4095)),
                   MOD_BITS'($urandom) | MOD_BITS'(32'h8000_0000)};
        foreach (moduli[p]) begin
            set_modulus(moduli[p]);
            sender_gaps_on = ($urandom_range(0, 1) == 1);
            repeat (PHASE_REQUESTS) begin
                if ($urandom_range(0, 31) == 0) sender_gaps_on = !sender_gaps_on;
                op = ($urandom_range(0, 99) < 8) ? mexp_pkg::OP_INVERSE
                                                 : mexp_pkg::OP_POWER;
                send_request(op, pick_base(), pick_exponent());
            end
        end
        sender_gaps_on = 1'b1;
    endtask

    // Results cannot be held off, so each strobe is checked at the edge ending it.
    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_powers.size() == 0) begin
                error_count++;
                $display("%0t: unexpected result, expected none, actual %0d",
                         $time, o_power_result);
            end else begin
                wanted_power = pending_powers.pop_front();
                powers_checked++;
                if (o_power_result !== wanted_power) begin
                    error_count++;
                    $display("%0t: power_result mismatch, expected %0d, actual %0d",
                             $time, wanted_power, o_power_result);
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((start && !busy) || o_done) begin
                stall_cycles <= 0;
            end else begin
                stall_cycles <= stall_cycles + 1;
            end
            if (stall_cycles >= STALL_LIMIT) begin
                $display("%0t: no progress for %0d cycles, %0d results outstanding",
                         $time, stall_cycles, pending_powers.size());
                $display("CHECKS FAILED");
                $finish;
            end
        end
    end

    initial begin
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_degenerate_moduli();
        test_full_width_moduli();
        test_random_sweep();
        drain_requests();
        repeat (100) @(posedge i_clk);
        $display("Sent %0d requests (%0d inverse, %0d with a full 63-bit exponent),",
                 requests_sent, inverse_requests, full_exponents);
        $display("checked %0d; moduli written: %0d, from zero up to the 32-bit maximum.",
                 powers_checked, moduli_written);
        if (error_count == 0 && pending_powers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

// ----- modular_exponentiation.f -----
sv/mexp_pkg.sv
sv/modular_exponentiation.sv
tb/sv/tb_top.sv
